### rtl/core/hiee_pkg.sv
`timescale 1ns / 1ps

package hiee_pkg;

   // Stack geometry
   localparam int STACK_DEPTH = 16;
   localparam int ADDR_W      = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
   localparam int CNT_W       = $clog2(STACK_DEPTH + 1);
   localparam int VALUE_W     = 32;
   localparam int OP_W        = 2;

   // Character codes
   localparam logic [7:0] CHR_MUL   = 8'h2A;
   localparam logic [7:0] CHR_ADD   = 8'h2B;
   localparam logic [7:0] CHR_OPEN  = 8'h28;
   localparam logic [7:0] CHR_CLOSE = 8'h29;
   localparam logic [7:0] CHR_SPACE = 8'h20;
   localparam logic [7:0] CHR_TAB   = 8'h09;
   localparam logic [7:0] CHR_CR    = 8'h0D;
   localparam logic [7:0] CHR_UA    = 8'h41;
   localparam logic [7:0] CHR_UF    = 8'h46;
   localparam logic [7:0] CHR_ZERO  = 8'h30;
   localparam logic [7:0] HEX_TEN   = 8'd10;

   // Operator codes as stored on the operator stack; code order is precedence order
   typedef enum logic [OP_W-1:0] {
      OP_OPEN = 2'd0,
      OP_ADD  = 2'd1,
      OP_MUL  = 2'd2
   } op_type;

   // Which scan drives the operator loop
   typedef enum logic [1:0] {
      MODE_OPER  = 2'd0,
      MODE_CLOSE = 2'd1,
      MODE_END   = 2'd2
   } mode_type;

   typedef enum logic [3:0] {
      ST_IDLE     = 4'd0,
      ST_LOOP_RD  = 4'd1,
      ST_LOOP_CHK = 4'd2,
      ST_RED_A    = 4'd3,
      ST_RED_B    = 4'd4,
      ST_RED_EXEC = 4'd5,
      ST_FIN_RD   = 4'd6,
      ST_FIN_WAIT = 4'd7,
      ST_FIN_OUT  = 4'd8
   } state_type;

   // Operand stack port
   typedef struct packed {
      logic               we;
      logic [ADDR_W-1:0]  waddr;
      logic [VALUE_W-1:0] wdata;
      logic [ADDR_W-1:0]  raddr;
   } opd_mem_req_type;

   // Operator stack port
   typedef struct packed {
      logic              we;
      logic [ADDR_W-1:0] waddr;
      logic [OP_W-1:0]   wdata;
      logic [ADDR_W-1:0] raddr;
   } opr_mem_req_type;

   // Final result handed to the output register
   typedef struct packed {
      logic               load;
      logic [VALUE_W-1:0] value;
      logic               status;
   } result_type;

   function automatic logic is_space(input logic [7:0] sym);
      return (sym == CHR_SPACE) || ((sym >= CHR_TAB) && (sym <= CHR_CR));
   endfunction

   // 'A'..'F' give ten to fifteen, anything else is the code minus '0', wrapped
   function automatic logic [VALUE_W-1:0] operand_value(input logic [7:0] sym);
      logic [VALUE_W-1:0] res;
      if ((sym >= CHR_UA) && (sym <= CHR_UF)) begin
         res = VALUE_W'(sym - CHR_UA + HEX_TEN);
      end else begin
         res = VALUE_W'(sym) - VALUE_W'(CHR_ZERO);
      end
      return res;
   endfunction

endpackage

### rtl/core/hex_infix_expression_evaluator.sv
`timescale 1ns / 1ps

// Infix expression evaluator over single hex-digit operands, '+', '*' and parentheses.
// Input channel req_: one character per transfer; req_tuser high marks the end of an
// expression, and req_tdata then carries nothing of use. Result channel rsp_: one
// transfer per end item, carrying the 32-bit wrapped value and the error status.
// Both stacks sit in single-port-write RAMs with a registered read.
// An operand, whitespace or '(' is handled in the accepting cycle; '+', '*' and ')'
// scan the operator stack and apply each operator they pop, or only pop it when fewer
// than two operands are stacked. An end item scans the whole operator stack in the
// same way, dropping open parens, then reads the top operand and loads the result;
// rsp_tvalid rises in the next cycle, together with req_tready. The rate is set by the
// operator stack read loop and the two operand reads each reduction needs on one port.
// Reset clears both stack counts, the error flag and the result valid flag; RAM
// contents are left as they are. A result waits in the output register while
// rsp_tready is low; character items are still taken meanwhile, and the next end item
// is taken but holds the input side until the waiting result is transferred.
module hex_infix_expression_evaluator (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,   // [7:0] symbol
   input  logic        req_tuser,   // [0] cmd
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [31:0] rsp_tdata,   // [31:0] value
   output logic        rsp_tuser    // [0] status
);

   hiee_pkg::result_type             result;
   hiee_pkg::opd_mem_req_type        opd_req;
   hiee_pkg::opr_mem_req_type        opr_req;
   logic [hiee_pkg::VALUE_W-1:0]     opd_rdata;
   logic [hiee_pkg::OP_W-1:0]        opr_rdata;
   logic                             out_busy;
   logic                             rsp_valid_ff, rsp_valid_in;
   logic [hiee_pkg::VALUE_W-1:0]     rsp_value_ff, rsp_value_in;
   logic                             rsp_status_ff, rsp_status_in;

   assign out_busy = rsp_valid_ff && !rsp_tready;

   hiee_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (req_tvalid),
      .in_ready  (req_tready),
      .in_cmd    (req_tuser),
      .in_symbol (req_tdata),
      .out_busy  (out_busy),
      .result    (result),
      .opd_req   (opd_req),
      .opd_rdata (opd_rdata),
      .opr_req   (opr_req),
      .opr_rdata (opr_rdata)
   );

   hiee_ram #(
      .WIDTH (hiee_pkg::VALUE_W),
      .DEPTH (hiee_pkg::STACK_DEPTH)
   ) u_opd_ram (
      .clock (clock),
      .we    (opd_req.we),
      .waddr (opd_req.waddr),
      .wdata (opd_req.wdata),
      .raddr (opd_req.raddr),
      .rdata (opd_rdata)
   );

   hiee_ram #(
      .WIDTH (hiee_pkg::OP_W),
      .DEPTH (hiee_pkg::STACK_DEPTH)
   ) u_opr_ram (
      .clock (clock),
      .we    (opr_req.we),
      .waddr (opr_req.waddr),
      .wdata (opr_req.wdata),
      .raddr (opr_req.raddr),
      .rdata (opr_rdata)
   );

   // Load a new result, drop the old one once transferred
   always_comb begin
      rsp_valid_in  = rsp_valid_ff;
      rsp_value_in  = rsp_value_ff;
      rsp_status_in = rsp_status_ff;
      if (result.load) begin
         rsp_valid_in  = 1'b1;
         rsp_value_in  = result.value;
         rsp_status_in = result.status;
      end else if (rsp_valid_ff && rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_value_ff  <= rsp_value_in;
      rsp_status_ff <= rsp_status_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_value_ff;
   assign rsp_tuser  = rsp_status_ff;

endmodule

### rtl/core/hiee_ram.sv
`timescale 1ns / 1ps

module hiee_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 16
) (
   input  logic                                       clock,
   input  logic                                       we,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
   input  logic [WIDTH-1:0]                           wdata,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
   output logic [WIDTH-1:0]                           rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];

   // Write one entry, register the read
   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      rdata <= mem_ff[raddr];
   end

endmodule

### rtl/core/hiee_ctrl.sv
`timescale 1ns / 1ps

module hiee_ctrl (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             in_valid,
   output logic                             in_ready,
   input  logic                             in_cmd,
   input  logic [7:0]                       in_symbol,
   input  logic                             out_busy,
   output hiee_pkg::result_type             result,
   output hiee_pkg::opd_mem_req_type        opd_req,
   input  logic [hiee_pkg::VALUE_W-1:0]     opd_rdata,
   output hiee_pkg::opr_mem_req_type        opr_req,
   input  logic [hiee_pkg::OP_W-1:0]        opr_rdata
);

   hiee_pkg::state_type              state_ff, state_in;
   hiee_pkg::mode_type               mode_ff, mode_in;
   hiee_pkg::op_type                 op_ff, op_in;
   logic [hiee_pkg::CNT_W-1:0]       opd_cnt_ff, opd_cnt_in;
   logic [hiee_pkg::CNT_W-1:0]       opr_cnt_ff, opr_cnt_in;
   logic                             err_ff, err_in;
   logic [hiee_pkg::VALUE_W-1:0]     a_ff, a_in;
   logic [hiee_pkg::VALUE_W-1:0]     value_ff, value_in;

   logic                             accept;
   logic                             sym_space, sym_oper, sym_open, sym_close;
   logic [hiee_pkg::CNT_W-1:0]       opd_m1, opd_m2, opr_m1;
   logic                             opd_full, opr_full, opr_empty, opd_short;
   logic                             top_open, reduce_now;

   assign accept    = in_valid && in_ready;
   assign in_ready  = (state_ff == hiee_pkg::ST_IDLE);

   // Character decode
   assign sym_space = hiee_pkg::is_space(in_symbol);
   assign sym_oper  = (in_symbol == hiee_pkg::CHR_ADD) || (in_symbol == hiee_pkg::CHR_MUL);
   assign sym_open  = (in_symbol == hiee_pkg::CHR_OPEN);
   assign sym_close = (in_symbol == hiee_pkg::CHR_CLOSE);

   // Stack pointers and limits
   assign opd_m1    = opd_cnt_ff - hiee_pkg::CNT_W'(1);
   assign opd_m2    = opd_cnt_ff - hiee_pkg::CNT_W'(2);
   assign opr_m1    = opr_cnt_ff - hiee_pkg::CNT_W'(1);
   assign opd_full  = (opd_cnt_ff >= hiee_pkg::CNT_W'(hiee_pkg::STACK_DEPTH));
   assign opr_full  = (opr_cnt_ff >= hiee_pkg::CNT_W'(hiee_pkg::STACK_DEPTH));
   assign opr_empty = (opr_cnt_ff == '0);
   assign opd_short = (opd_cnt_ff < hiee_pkg::CNT_W'(2));

   // Decide whether the operator on top must be applied now
   assign top_open   = (opr_rdata == hiee_pkg::OP_OPEN);
   assign reduce_now = (mode_ff == hiee_pkg::MODE_OPER) ? (opr_rdata >= op_ff) : !top_open;

   // Next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         hiee_pkg::ST_IDLE: begin
            if (accept) begin
               if (in_cmd) begin
                  state_in = hiee_pkg::ST_LOOP_RD;
               end else if (!sym_space && (sym_oper || sym_close)) begin
                  state_in = hiee_pkg::ST_LOOP_RD;
               end
            end
         end
         hiee_pkg::ST_LOOP_RD: begin
            if (!opr_empty) begin
               state_in = hiee_pkg::ST_LOOP_CHK;
            end else if (mode_ff == hiee_pkg::MODE_END) begin
               state_in = hiee_pkg::ST_FIN_RD;
            end else begin
               state_in = hiee_pkg::ST_IDLE;
            end
         end
         hiee_pkg::ST_LOOP_CHK: begin
            if (reduce_now) begin
               state_in = opd_short ? hiee_pkg::ST_LOOP_RD : hiee_pkg::ST_RED_A;
            end else if (mode_ff == hiee_pkg::MODE_END) begin
               state_in = hiee_pkg::ST_LOOP_RD;
            end else begin
               state_in = hiee_pkg::ST_IDLE;
            end
         end
         hiee_pkg::ST_RED_A:    state_in = hiee_pkg::ST_RED_B;
         hiee_pkg::ST_RED_B:    state_in = hiee_pkg::ST_RED_EXEC;
         hiee_pkg::ST_RED_EXEC: state_in = hiee_pkg::ST_LOOP_RD;
         hiee_pkg::ST_FIN_RD: begin
            state_in = (opd_cnt_ff != '0) ? hiee_pkg::ST_FIN_WAIT : hiee_pkg::ST_FIN_OUT;
         end
         hiee_pkg::ST_FIN_WAIT: state_in = hiee_pkg::ST_FIN_OUT;
         hiee_pkg::ST_FIN_OUT: begin
            if (!out_busy) begin
               state_in = hiee_pkg::ST_IDLE;
            end
         end
         default: state_in = hiee_pkg::ST_IDLE;
      endcase
   end

   // Datapath, stack counts and memory requests
   always_comb begin
      mode_in       = mode_ff;
      op_in         = op_ff;
      opd_cnt_in    = opd_cnt_ff;
      opr_cnt_in    = opr_cnt_ff;
      err_in        = err_ff;
      a_in          = a_ff;
      value_in      = value_ff;
      opd_req.we    = 1'b0;
      opd_req.waddr = opd_cnt_ff[hiee_pkg::ADDR_W-1:0];
      opd_req.wdata = hiee_pkg::operand_value(in_symbol);
      opd_req.raddr = opd_m1[hiee_pkg::ADDR_W-1:0];
      opr_req.we    = 1'b0;
      opr_req.waddr = opr_cnt_ff[hiee_pkg::ADDR_W-1:0];
      opr_req.wdata = op_ff;
      opr_req.raddr = opr_m1[hiee_pkg::ADDR_W-1:0];
      result.load   = 1'b0;
      result.value  = value_ff;
      result.status = err_ff;
      case (state_ff)
         hiee_pkg::ST_IDLE: begin
            if (accept) begin
               if (in_cmd) begin
                  mode_in = hiee_pkg::MODE_END;
               end else if (sym_space) begin
                  // skip whitespace
               end else if (sym_oper) begin
                  mode_in = hiee_pkg::MODE_OPER;
                  op_in   = (in_symbol == hiee_pkg::CHR_MUL) ? hiee_pkg::OP_MUL
                                                             : hiee_pkg::OP_ADD;
               end else if (sym_open) begin
                  // push open paren
                  opr_req.wdata = hiee_pkg::OP_OPEN;
                  if (opr_full) begin
                     err_in = 1'b1;
                  end else begin
                     opr_req.we = 1'b1;
                     opr_cnt_in = opr_cnt_ff + hiee_pkg::CNT_W'(1);
                  end
               end else if (sym_close) begin
                  mode_in = hiee_pkg::MODE_CLOSE;
               end else begin
                  // push operand
                  if (opd_full) begin
                     err_in = 1'b1;
                  end else begin
                     opd_req.we = 1'b1;
                     opd_cnt_in = opd_cnt_ff + hiee_pkg::CNT_W'(1);
                  end
               end
            end
         end
         hiee_pkg::ST_LOOP_RD: begin
            if (opr_empty) begin
               if (mode_ff == hiee_pkg::MODE_OPER) begin
                  opr_req.we = 1'b1;
                  opr_cnt_in = opr_cnt_ff + hiee_pkg::CNT_W'(1);
               end else if (mode_ff == hiee_pkg::MODE_CLOSE) begin
                  err_in = 1'b1;
               end
            end
         end
         hiee_pkg::ST_LOOP_CHK: begin
            if (reduce_now) begin
               // pop the operator; too few operands flags an error
               opr_cnt_in = opr_m1;
               op_in      = (mode_ff == hiee_pkg::MODE_OPER) ? op_ff
                                                             : hiee_pkg::op_type'(opr_rdata);
               if (opd_short) begin
                  err_in = 1'b1;
               end
               // keep the pending operator, borrow a_ff for the one applied
               a_in = hiee_pkg::VALUE_W'(opr_rdata);
            end else if (mode_ff == hiee_pkg::MODE_OPER) begin
               if (opr_full) begin
                  err_in = 1'b1;
               end else begin
                  opr_req.we = 1'b1;
                  opr_cnt_in = opr_cnt_ff + hiee_pkg::CNT_W'(1);
               end
            end else begin
               // drop the open paren
               opr_cnt_in = opr_m1;
            end
         end
         hiee_pkg::ST_RED_A: begin
            // a_ff holds the code of the operator being applied
            value_in = a_ff;
         end
         hiee_pkg::ST_RED_B: begin
            opd_req.raddr = opd_m2[hiee_pkg::ADDR_W-1:0];
            a_in          = opd_rdata;
         end
         hiee_pkg::ST_RED_EXEC: begin
            opd_req.we    = 1'b1;
            opd_req.waddr = opd_m2[hiee_pkg::ADDR_W-1:0];
            if (value_ff[hiee_pkg::OP_W-1:0] == hiee_pkg::OP_MUL) begin
               opd_req.wdata = a_ff * opd_rdata;
            end else begin
               opd_req.wdata = a_ff + opd_rdata;
            end
            opd_cnt_in = opd_m1;
         end
         hiee_pkg::ST_FIN_RD: begin
            value_in = '0;
         end
         hiee_pkg::ST_FIN_WAIT: begin
            value_in = opd_rdata;
         end
         hiee_pkg::ST_FIN_OUT: begin
            if (!out_busy) begin
               result.load = 1'b1;
               opd_cnt_in  = '0;
               opr_cnt_in  = '0;
               err_in      = 1'b0;
            end
         end
         default: begin
         end
      endcase
   end

   // Control state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= hiee_pkg::ST_IDLE;
         opd_cnt_ff <= '0;
         opr_cnt_ff <= '0;
         err_ff     <= 1'b0;
         mode_ff    <= hiee_pkg::MODE_OPER;
         op_ff      <= hiee_pkg::OP_ADD;
      end else begin
         state_ff   <= state_in;
         opd_cnt_ff <= opd_cnt_in;
         opr_cnt_ff <= opr_cnt_in;
         err_ff     <= err_in;
         mode_ff    <= mode_in;
         op_ff      <= op_in;
      end
   end

   // Operand holding registers
   always_ff @(posedge clock) begin
      a_ff     <= a_in;
      value_ff <= value_in;
   end

endmodule

### rtl/core/hiee_checker.sv
`timescale 1ns / 1ps

module hiee_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_tvalid,
   input logic        req_tready,
   input logic        req_tuser,
   input logic        rsp_tvalid,
   input logic        rsp_tready,
   input logic [31:0] rsp_tdata
);

   // Result register is empty after reset
   assert property (@(posedge clock) reset |=> !rsp_tvalid)
      else $error("result valid after reset");

   // A stalled result holds
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("stalled result changed");

   // A character item never creates a result
   assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready && !req_tuser && !rsp_tvalid |=> !rsp_tvalid)
      else $error("result appeared after a character item");

   // An end item keeps the input side busy for the final reduction
   assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready && req_tuser |=> !req_tready)
      else $error("input ready right after an end item");

endmodule

bind hex_infix_expression_evaluator hiee_checker u_hiee_checker (.*);
